/* hdl/assert_macros.svh */
// Assertion macros for the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A concurrent assertion sampled on a given clock and held off during reset.
`define UPE_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
        else $error(msg);

// The same on the usual clock and reset names of the block.
`define UPE_ASSERT_CLK(lbl, prop, msg) \
    `UPE_ASSERT(lbl, clk, rst_n, prop, msg)

`endif

/* hdl/upe_pkg.sv */
package upe_pkg;

    // What the back end has to produce for one queued transaction.
    typedef enum logic [1:0] {
        JOB_LIT,
        JOB_PCT,
        JOB_ERR
    } job_kind_t;

    // One queued transaction: a literal character, up to four escaped bytes or an error.
    typedef struct packed {
        job_kind_t        kind;
        logic [1:0]       last_byte;
        logic [3:0][7:0]  bytes;
        logic             eot;
    } job_t;

    // Position within one %XX escape.
    typedef enum logic [1:0] {
        PH_PCT,
        PH_HI,
        PH_LO
    } digit_phase_t;

    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;
    localparam logic [15:0] FIRST_PRINTABLE = 16'd33;
    localparam logic [15:0] FIRST_NON_ASCII = 16'd128;
    localparam logic [15:0] FIRST_3BYTE     = 16'h0800;
    localparam logic [20:0] PLANE1_BASE     = 21'h10000;

    localparam logic [6:0]  ASCII_PERCENT   = 7'h25;
    localparam logic [6:0]  ASCII_NUL       = 7'h00;

    // Word index of the component mode register on the configuration port.
    localparam logic        CFG_IDX_COMPONENT_MODE = 1'b0;

    // Letters, digits and - _ . ! ~ * ' ( ).
    function automatic logic is_unreserved(input logic [6:0] c);
        return c inside {[7'h61:7'h7A], [7'h41:7'h5A], [7'h30:7'h39],
                         7'h2D, 7'h5F, 7'h2E, 7'h21, 7'h7E, 7'h2A, 7'h27, 7'h28, 7'h29};
    endfunction

    // ; / ? : @ & = + $ , #
    function automatic logic is_reserved(input logic [6:0] c);
        return c inside {7'h3B, 7'h2F, 7'h3F, 7'h3A, 7'h40, 7'h26,
                         7'h3D, 7'h2B, 7'h24, 7'h2C, 7'h23};
    endfunction

    // Upper-case hexadecimal digit.
    function automatic logic [6:0] hex_char(input logic [3:0] n);
        logic [6:0] wide;
        wide = {3'b000, n};
        return (n < 4'd10) ? (7'h30 + wide) : (7'h37 + wide);
    endfunction

endpackage

/* hdl/upe_front.sv */
module upe_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  logic [15:0]     code_unit,
    input  logic            end_of_text,
    input  logic            component_mode,
    output logic            push,
    output upe_pkg::job_t   job
);
    import upe_pkg::*;

    logic [9:0]  held_high_bits_reg;
    logic [9:0]  held_high_bits_next;
    logic        high_pending_reg;
    logic        high_pending_next;
    logic        error_hold_reg;
    logic        error_hold_next;
    logic        has_job;
    logic        is_err;
    logic [20:0] scalar;

    // Code point rebuilt from a held high surrogate and the current low surrogate.
    assign scalar = {1'b0, held_high_bits_reg, code_unit[9:0]} + PLANE1_BASE;

    // Classify the code unit and decide what the back end must emit.
    always_comb
    begin
        held_high_bits_next = held_high_bits_reg;
        high_pending_next   = high_pending_reg;
        error_hold_next     = error_hold_reg;
        has_job             = 1'b0;
        is_err              = 1'b0;
        job.kind            = JOB_PCT;
        job.last_byte       = 2'd0;
        job.bytes           = '0;
        job.eot             = end_of_text;

        if (error_hold_reg)
        begin
            if (end_of_text)
            begin
                error_hold_next = 1'b0;
            end
        end
        else if (high_pending_reg)
        begin
            high_pending_next   = 1'b0;
            held_high_bits_next = '0;
            if (code_unit inside {[LOW_SURR_FIRST:LOW_SURR_LAST]})
            begin
                has_job       = 1'b1;
                job.last_byte = 2'd3;
                job.bytes[0]  = {5'b11110, scalar[20:18]};
                job.bytes[1]  = {2'b10, scalar[17:12]};
                job.bytes[2]  = {2'b10, scalar[11:6]};
                job.bytes[3]  = {2'b10, scalar[5:0]};
            end
            else
            begin
                is_err = 1'b1;
            end
        end
        else if (code_unit < FIRST_PRINTABLE)
        begin
            has_job      = 1'b1;
            job.bytes[0] = code_unit[7:0];
        end
        else if (code_unit < FIRST_NON_ASCII)
        begin
            has_job      = 1'b1;
            job.bytes[0] = code_unit[7:0];
            if (is_unreserved(code_unit[6:0]) ||
                (!component_mode && is_reserved(code_unit[6:0])))
            begin
                job.kind = JOB_LIT;
            end
        end
        else if (code_unit inside {[LOW_SURR_FIRST:LOW_SURR_LAST]})
        begin
            is_err = 1'b1;
        end
        else if (code_unit inside {[HIGH_SURR_FIRST:HIGH_SURR_LAST]})
        begin
            if (end_of_text)
            begin
                is_err = 1'b1;
            end
            else
            begin
                high_pending_next   = 1'b1;
                held_high_bits_next = code_unit[9:0];
            end
        end
        else if (code_unit < FIRST_3BYTE)
        begin
            has_job       = 1'b1;
            job.last_byte = 2'd1;
            job.bytes[0]  = {3'b110, code_unit[10:6]};
            job.bytes[1]  = {2'b10, code_unit[5:0]};
        end
        else
        begin
            has_job       = 1'b1;
            job.last_byte = 2'd2;
            job.bytes[0]  = {4'b1110, code_unit[15:12]};
            job.bytes[1]  = {2'b10, code_unit[11:6]};
            job.bytes[2]  = {2'b10, code_unit[5:0]};
        end

        // A malformed surrogate gives a single error result and, unless the text ends there, starts the discard.
        if (is_err)
        begin
            has_job  = 1'b1;
            job.kind = JOB_ERR;
            if (!end_of_text)
            begin
                error_hold_next = 1'b1;
            end
        end
    end

    assign push = accept && has_job;

    // Surrogate and error state advance only on an accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_high_bits_reg <= '0;
            high_pending_reg   <= 1'b0;
            error_hold_reg     <= 1'b0;
        end
        else if (accept)
        begin
            held_high_bits_reg <= held_high_bits_next;
            high_pending_reg   <= high_pending_next;
            error_hold_reg     <= error_hold_next;
        end
    end

endmodule

/* hdl/upe_queue.sv */
module upe_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  upe_pkg::job_t   push_job,
    input  logic            pop,
    output upe_pkg::job_t   pop_job,
    output logic            full,
    output logic            avail
);
    import upe_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t           entry_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW-1:0]  rd_ptr_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;

    assign full    = (count_reg == CW'(DEPTH));
    assign avail   = (count_reg != '0);
    assign pop_job = entry_reg[rd_ptr_reg];

    // Pointer wrap and occupancy.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* hdl/upe_back.sv */
module upe_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  upe_pkg::job_t   job_in,
    input  logic            job_avail,
    output logic            pop,
    input  logic            char_stall,
    output logic            char_valid,
    output logic [6:0]      out_char,
    output logic            run_last,
    output logic            text_end,
    output logic            uri_error
);
    import upe_pkg::*;

    job_t          work_reg;
    logic          work_valid_reg;
    logic          work_valid_next;
    logic [1:0]    byte_idx_reg;
    logic [1:0]    byte_idx_next;
    digit_phase_t  phase_reg;
    digit_phase_t  phase_next;
    logic          out_valid_reg;
    logic [6:0]    out_char_reg;
    logic          run_last_reg;
    logic          text_end_reg;
    logic          uri_error_reg;

    logic [7:0]    cur_byte;
    logic [6:0]    gen_char;
    logic          gen_last;
    logic          gen_err;
    logic          advance;

    assign advance  = work_valid_reg && (!out_valid_reg || !char_stall);
    assign cur_byte = work_reg.bytes[byte_idx_reg];

    // Character for the current position in the transaction.
    always_comb
    begin
        gen_char = ASCII_NUL;
        gen_last = 1'b1;
        gen_err  = 1'b0;
        case (work_reg.kind)
            JOB_LIT:
            begin
                gen_char = work_reg.bytes[0][6:0];
            end
            JOB_PCT:
            begin
                gen_last = 1'b0;
                case (phase_reg)
                    PH_PCT:  gen_char = ASCII_PERCENT;
                    PH_HI:   gen_char = hex_char(cur_byte[7:4]);
                    PH_LO:
                    begin
                        gen_char = hex_char(cur_byte[3:0]);
                        gen_last = (byte_idx_reg == work_reg.last_byte);
                    end
                    default: gen_char = ASCII_PERCENT;
                endcase
            end
            default:
            begin
                gen_err = 1'b1;
            end
        endcase
    end

    // Next position: for an escape, through the three characters of each byte, then the next byte.
    always_comb
    begin
        phase_next    = phase_reg;
        byte_idx_next = byte_idx_reg;
        if (advance)
        begin
            if (gen_last)
            begin
                phase_next    = PH_PCT;
                byte_idx_next = 2'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_PCT:  phase_next = PH_HI;
                    PH_HI:   phase_next = PH_LO;
                    PH_LO:
                    begin
                        phase_next    = PH_PCT;
                        byte_idx_next = byte_idx_reg + 2'd1;
                    end
                    default: phase_next = PH_PCT;
                endcase
            end
        end
    end

    // Take the next transaction when idle or on the final character of this one.
    assign pop = job_avail && (!work_valid_reg || (advance && gen_last));

    always_comb
    begin
        work_valid_next = work_valid_reg;
        if (pop)
        begin
            work_valid_next = 1'b1;
        end
        else if (advance && gen_last)
        begin
            work_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_valid_reg <= 1'b0;
            phase_reg      <= PH_PCT;
            byte_idx_reg   <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            work_valid_reg <= work_valid_next;
            phase_reg      <= phase_next;
            byte_idx_reg   <= byte_idx_next;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!char_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: the work transaction and the output character.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            work_reg <= job_in;
        end
        if (advance)
        begin
            out_char_reg  <= gen_char;
            run_last_reg  <= gen_last;
            text_end_reg  <= gen_last && work_reg.eot;
            uri_error_reg <= gen_err;
        end
    end

    assign char_valid = out_valid_reg;
    assign out_char   = out_char_reg;
    assign run_last   = run_last_reg;
    assign text_end   = text_end_reg;
    assign uri_error  = uri_error_reg;

endmodule

/* hdl/uri_percent_encoder_utf16.sv */
// URI percent encoder for UTF-16 text. One code unit enters per transaction on the
// unit channel and the encoded text leaves one ASCII character per transaction on the
// char channel. A code unit gives one character (plain ASCII), three (an escaped ASCII
// byte), six or nine (two- or three-byte UTF-8), twelve (a surrogate pair, counted on
// its low half), a single error result, or nothing (a held high surrogate, or a unit
// discarded after an error until end of text). The output register delivers one
// character per cycle while char_stall is low; the front end takes a unit every cycle
// while the QUEUE_DEPTH-entry queue has room. A unit passes the queue entry, the work
// register and the output register before its first character. The user must write
// component_mode over the APB port at byte address 0 only while the block is idle; the
// block itself does not enforce this. 1 escapes the reserved characters as well.
module uri_percent_encoder_utf16
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // Code unit channel.
    input  logic         unit_valid,
    output logic         unit_stall,
    input  logic [15:0]  code_unit,
    input  logic         end_of_text,
    // Character channel.
    output logic         char_valid,
    input  logic         char_stall,
    output logic [6:0]   out_char,
    output logic         run_last,
    output logic         text_end,
    output logic         uri_error
);
    import upe_pkg::*;

    logic  component_mode_reg;
    logic  cfg_write;
    logic  accept;
    logic  push;
    logic  pop;
    logic  q_full;
    logic  q_avail;
    job_t  front_job;
    job_t  queued_job;

    // Register access.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            component_mode_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[2] == CFG_IDX_COMPONENT_MODE))
        begin
            component_mode_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_COMPONENT_MODE) ? {31'd0, component_mode_reg} : '0;

    // Input is held off only while the queue is full.
    assign unit_stall = q_full;
    assign accept     = unit_valid && !q_full;

    upe_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .code_unit      (code_unit),
        .end_of_text    (end_of_text),
        .component_mode (component_mode_reg),
        .push           (push),
        .job            (front_job)
    );

    upe_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (front_job),
        .pop      (pop),
        .pop_job  (queued_job),
        .full     (q_full),
        .avail    (q_avail)
    );

    upe_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_in     (queued_job),
        .job_avail  (q_avail),
        .pop        (pop),
        .char_stall (char_stall),
        .char_valid (char_valid),
        .out_char   (out_char),
        .run_last   (run_last),
        .text_end   (text_end),
        .uri_error  (uri_error)
    );

endmodule

/* hdl/upe_checker.sv */
`include "assert_macros.svh"

module upe_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         char_valid,
    input  logic         char_stall,
    input  logic [6:0]   out_char,
    input  logic         run_last,
    input  logic         text_end,
    input  logic         uri_error
);

    // A stalled character transaction stays offered unchanged.
    `UPE_ASSERT_CLK(a_char_hold, char_valid && char_stall |=> char_valid && $stable(out_char) && $stable(run_last) && $stable(text_end) && $stable(uri_error), "stalled character changed")

    // An error result carries no character and closes its input.
    `UPE_ASSERT_CLK(a_error_form, char_valid && uri_error |-> out_char == 7'h00 && run_last, "malformed error result")

    // The end of the text is always the end of an input's results.
    `UPE_ASSERT_CLK(a_end_is_last, char_valid && text_end |-> run_last, "text end without run end")

    // Every encoded character is printable, never NUL.
    `UPE_ASSERT_CLK(a_char_printable, char_valid && !uri_error |-> out_char > 7'h20, "unprintable character emitted")

endmodule

bind uri_percent_encoder_utf16 upe_checker u_upe_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .out_char   (out_char),
    .run_last   (run_last),
    .text_end   (text_end),
    .uri_error  (uri_error)
);

/* test/uri_encode_checker.sv */
`timescale 1ns / 100ps

// Watches both channels and the configuration port of the URI encoder, works out the
// characters each accepted code unit should produce and compares them, in order, with
// the characters the block delivers.
module uri_encode_checker
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic         pready,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    input  logic         unit_valid,
    input  logic         unit_stall,
    input  logic [15:0]  code_unit,
    input  logic         end_of_text,
    input  logic         char_valid,
    input  logic         char_stall,
    input  logic [6:0]   out_char,
    input  logic         run_last,
    input  logic         text_end,
    input  logic         uri_error,
    output int           mismatches,
    output int           outstanding
);
    import upe_pkg::*;

    // One character transaction as the block should deliver it.
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
        logic       tend;
        logic       err;
    } char_result_t;

    char_result_t expected_chars[$];
    char_result_t unit_chars[$];

    // Encoder state, kept in step with the block.
    logic [9:0] held_bits;
    logic       high_held;
    logic       discarding;
    logic       escape_reserved;

    int fail_total = 0;
    int pending_total = 0;
    int char_index = 0;

    assign mismatches  = fail_total;
    assign outstanding = pending_total;

    task automatic report_mismatch(input string msg);
        $display("%0t uri_encode_checker: %s", $time, msg);
        fail_total = fail_total + 1;
    endtask

    function automatic logic [6:0] hex_digit(input logic [3:0] n);
        logic [6:0] d;
        d = 7'(n);
        return (n < 4'd10) ? 7'h30 + d : 7'h41 + d - 7'd10;
    endfunction

    function automatic bit ascii_unreserved(input logic [6:0] c);
        if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
            return 1'b1;
        case (c)
            "-", "_", ".", "!", "~", "*", "'", "(", ")": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit ascii_reserved(input logic [6:0] c);
        case (c)
            ";", "/", "?", ":", "@", "&", "=", "+", "$", ",", "#": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void push_char(input logic [6:0] c);
        unit_chars.push_back('{ch: c, last: 1'b0, tend: 1'b0, err: 1'b0});
    endfunction

    function automatic void push_escape(input logic [7:0] b);
        push_char(ASCII_PERCENT);
        push_char(hex_digit(b[7:4]));
        push_char(hex_digit(b[3:0]));
    endfunction

    // UTF-8 bytes of one scalar value at or above 0x80, each written as an escape.
    function automatic void push_utf8(input logic [20:0] v);
        if (v < 21'h800) begin
            push_escape({3'b110, v[10:6]});
            push_escape({2'b10, v[5:0]});
        end
        else if (v < PLANE1_BASE) begin
            push_escape({4'b1110, v[15:12]});
            push_escape({2'b10, v[11:6]});
            push_escape({2'b10, v[5:0]});
        end
        else begin
            push_escape({5'b11110, v[20:18]});
            push_escape({2'b10, v[17:12]});
            push_escape({2'b10, v[11:6]});
            push_escape({2'b10, v[5:0]});
        end
    endfunction

    // Works out the characters caused by one code unit and queues them.
    function automatic void encode_unit(input logic [15:0] c, input logic eot);
        logic         bad;
        char_result_t tail;
        bad = 1'b0;
        unit_chars.delete();

        // After a malformed surrogate everything up to the end of the text is dropped.
        if (discarding) begin
            if (eot)
                discarding = 1'b0;
            return;
        end

        if (high_held) begin
            high_held = 1'b0;
            if (c >= LOW_SURR_FIRST && c <= LOW_SURR_LAST)
                push_utf8({1'b0, held_bits, c[9:0]} + PLANE1_BASE);
            else
                bad = 1'b1;
            held_bits = '0;
        end
        else if (c < FIRST_PRINTABLE) begin
            push_escape(c[7:0]);
        end
        else if (c < FIRST_NON_ASCII) begin
            if (ascii_unreserved(c[6:0]) || (!escape_reserved && ascii_reserved(c[6:0])))
                push_char(c[6:0]);
            else
                push_escape(c[7:0]);
        end
        else if (c >= LOW_SURR_FIRST && c <= LOW_SURR_LAST) begin
            bad = 1'b1;
        end
        else if (c >= HIGH_SURR_FIRST && c <= HIGH_SURR_LAST) begin
            // A high surrogate waits for its partner unless the text ends here.
            if (eot) begin
                bad = 1'b1;
            end
            else begin
                held_bits = c[9:0];
                high_held = 1'b1;
                return;
            end
        end
        else begin
            push_utf8({5'b0, c});
        end

        if (bad) begin
            unit_chars.delete();
            unit_chars.push_back('{ch: ASCII_NUL, last: 1'b0, tend: 1'b0, err: 1'b1});
            if (!eot)
                discarding = 1'b1;
        end

        if (unit_chars.size() > 0) begin
            tail = unit_chars.pop_back();
            tail.last = 1'b1;
            tail.tend = eot;
            unit_chars.push_back(tail);
        end
        foreach (unit_chars[i])
            expected_chars.push_back(unit_chars[i]);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        char_result_t want;
        if (!rst_n) begin
            held_bits = '0;
            high_held = 1'b0;
            discarding = 1'b0;
            escape_reserved = 1'b0;
            expected_chars.delete();
            pending_total <= 0;
        end
        else begin
            // Register write at the access phase; only word 0 exists, and only bit 0.
            if (psel && penable && pwrite && pready && paddr[2] == CFG_IDX_COMPONENT_MODE)
                escape_reserved = pwdata[0];

            // Compare a delivered character with the oldest one still awaited.
            if (char_valid && !char_stall) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("char %0d: unexpected transaction, out_char %h",
                                              char_index, out_char));
                end
                else begin
                    want = expected_chars.pop_front();
                    if (out_char !== want.ch)
                        report_mismatch($sformatf("char %0d: out_char %h, expected %h",
                                                  char_index, out_char, want.ch));
                    if (run_last !== want.last)
                        report_mismatch($sformatf("char %0d: run_last %b, expected %b",
                                                  char_index, run_last, want.last));
                    if (text_end !== want.tend)
                        report_mismatch($sformatf("char %0d: text_end %b, expected %b",
                                                  char_index, text_end, want.tend));
                    if (uri_error !== want.err)
                        report_mismatch($sformatf("char %0d: uri_error %b, expected %b",
                                                  char_index, uri_error, want.err));
                end
                char_index = char_index + 1;
            end

            if (unit_valid && !unit_stall)
                encode_unit(code_unit, end_of_text);

            pending_total <= expected_chars.size();
        end
    end

endmodule

/* test/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import upe_pkg::*;

    localparam int         CYCLE_LIMIT       = 250000;
    localparam int         SETTLE_CYCLES     = 8;
    localparam int         LONG_HOLD_CYCLES  = 80;
    localparam logic [2:0] ADDR_COMPONENT_MODE = {CFG_IDX_COMPONENT_MODE, 2'b00};
    localparam logic [2:0] ADDR_UNUSED       = 3'd4;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [2:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         unit_valid = 1'b0;
    logic         unit_stall;
    logic [15:0]  code_unit = '0;
    logic         end_of_text = 1'b0;
    logic         char_valid;
    logic         char_stall = 1'b0;
    logic [6:0]   out_char;
    logic         run_last;
    logic         text_end;
    logic         uri_error;

    int mismatches;
    int outstanding;
    int cycle_count = 0;

    // Shared between the sender and the receiver to shape the traffic.
    bit steady_flow = 1'b0;
    bit hold_off_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    uri_percent_encoder_utf16 dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .unit_valid  (unit_valid),
        .unit_stall  (unit_stall),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .out_char    (out_char),
        .run_last    (run_last),
        .text_end    (text_end),
        .uri_error   (uri_error)
    );

    uri_encode_checker encode_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .unit_valid  (unit_valid),
        .unit_stall  (unit_stall),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .out_char    (out_char),
        .run_last    (run_last),
        .text_end    (text_end),
        .uri_error   (uri_error),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // Character receiver: a random stall before each transaction, and a long hold-off
    // when the sender asks for one, so that the block's queue fills up.
    initial
    begin : char_sink
        int wait_cycles;
        forever begin
            if (hold_off_req) begin
                wait_cycles = LONG_HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            else begin
                wait_cycles = steady_flow ? 0 : $urandom_range(0, 4);
            end
            if (wait_cycles > 0) begin
                char_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            char_stall <= 1'b0;
            do @(posedge clk); while (!char_valid);
        end
    end

    // Offers one code unit after a random gap and returns at the edge it is taken.
    task automatic send_unit(input logic [15:0] cu, input logic eot);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            unit_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        unit_valid  <= 1'b1;
        code_unit   <= cu;
        end_of_text <= eot;
        do @(posedge clk); while (unit_stall);
    endtask

    // Stops offering and waits until every awaited character has been delivered.
    task automatic drain();
        unit_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One short text, mostly well-formed, with the odd malformed surrogate or stray unit.
    task automatic send_random_text(output int units);
        int   len;
        int   kind;
        logic last_one;
        units = 0;
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
            last_one = (k == len - 1);
            kind = $urandom_range(0, 99);
            if (kind < 30) begin
                send_unit(16'($urandom_range(0, 127)), last_one);
                units += 1;
            end
            else if (kind < 45) begin
                send_unit(16'($urandom_range('h80, 'h7FF)), last_one);
                units += 1;
            end
            else if (kind < 60) begin
                if ($urandom_range(0, 1) == 1)
                    send_unit(16'($urandom_range('h800, 'hD7FF)), last_one);
                else
                    send_unit(16'($urandom_range('hE000, 'hFFFF)), last_one);
                units += 1;
            end
            else if (kind < 85) begin
                send_unit(16'($urandom_range('hD800, 'hDBFF)), 1'b0);
                send_unit(16'($urandom_range('hDC00, 'hDFFF)), last_one);
                units += 2;
            end
            else if (kind < 90) begin
                send_unit(16'($urandom_range('hDC00, 'hDFFF)), last_one);
                units += 1;
            end
            else if (kind < 95) begin
                send_unit(16'($urandom_range('hD800, 'hDBFF)), 1'b0);
                send_unit(16'($urandom_range(0, 'hD7FF)), last_one);
                units += 2;
            end
            else begin
                send_unit(16'($urandom_range(0, 'hFFFF)), last_one);
                units += 1;
            end
        end
    endtask

    task automatic run_random_phase(input int target);
        int sent;
        int units;
        sent = 0;
        while (sent < target) begin
            send_random_text(units);
            sent += units;
        end
    endtask

    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts with reserved characters kept.
        send_unit(16'h0000, 1'b0);
        send_unit(16'h0020, 1'b0);
        send_unit(16'h0021, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h003B, 1'b0);
        send_unit(16'h0022, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        // Surrogate pairs at both ends of the range.
        send_unit(16'hD800, 1'b0);
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hDBFF, 1'b0);
        send_unit(16'hDFFF, 1'b1);
        // Lone low surrogate, then the rest of the text is dropped.
        send_unit(16'hDC00, 1'b0);
        send_unit(16'h0061, 1'b0);
        send_unit(16'h0062, 1'b1);
        // High surrogate followed by a plain character.
        send_unit(16'hD800, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'h0078, 1'b1);
        // High surrogate as the final unit, and a lone low surrogate as the final unit.
        send_unit(16'hDBFF, 1'b1);
        send_unit(16'hDFFF, 1'b1);
        drain();

        // Reserved characters escaped.
        write_reg(ADDR_COMPONENT_MODE, 32'hFFFF_FFFF);
        send_unit(16'h0023, 1'b0);
        send_unit(16'h002C, 1'b0);
        send_unit(16'h007E, 1'b1);
        drain();

        // A write to an unused word must leave the mode alone.
        write_reg(ADDR_UNUSED, 32'h0000_0000);
        run_random_phase(60);
        drain();

        // Only bit 0 counts, so this clears the mode.
        write_reg(ADDR_COMPONENT_MODE, 32'h0000_0002);
        run_random_phase(20);
        hold_off_req = 1'b1;
        steady_flow = 1'b1;
        run_random_phase(25);
        steady_flow = 1'b0;
        drain();
        run_random_phase(40);
        drain();

        write_reg(ADDR_COMPONENT_MODE, 32'h0000_0001);
        run_random_phase(40);
        steady_flow = 1'b1;
        run_random_phase(25);
        steady_flow = 1'b0;
        run_random_phase(20);
        drain();

        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
